[src/rgb_to_hsv_8bit_defines.svh]
// -----------------------------------------------------------------------------
// rgb_to_hsv_8bit_defines.svh
// Assertion macros shared by the checker of the RGB to HSV converter.
// -----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_8BIT_DEFINES_SVH
`define RGB_TO_HSV_8BIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RHSV_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgb_to_hsv_8bit: port check failed");

// Implication with a fixed delay in clock cycles.
`define RHSV_ASSERT_DELAY(label, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("rgb_to_hsv_8bit: port timing check failed");

`endif

[src/rhsv_pkg.sv]
// -----------------------------------------------------------------------------
// rhsv_pkg
// Types and constants shared by the RGB to HSV converter modules.
// -----------------------------------------------------------------------------
`default_nettype none

package rhsv_pkg;

    // Quotient bits per division, one division cell per bit
    localparam int DIV_STEPS  = 8;
    // Front stage + division cells + output register
    localparam int LATENCY    = DIV_STEPS + 2;

    localparam logic [7:0] HUE_BASE_RED   = 8'd0;
    localparam logic [7:0] HUE_BASE_GREEN = 8'd85;
    localparam logic [7:0] HUE_BASE_BLUE  = 8'd171;
    localparam logic [7:0] HUE_SCALE      = 8'd43;
    localparam logic [7:0] SAT_MAX        = 8'd255;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_t;

    typedef struct packed {
        logic [7:0] hue_out;
        logic [7:0] sat_out;
        logic [7:0] val_out;
    } hsv_t;

    // Partial state of one restoring division
    typedef struct packed {
        logic [7:0] rem;   // running remainder, stays below den if it starts below den
        logic [7:0] den;   // divisor
        logic [7:0] feed;  // dividend bits not yet shifted in, MSB first
        logic [7:0] quo;   // quotient bits produced so far
    } div_t;

    // Per-pixel data that rides along with the divisions
    typedef struct packed {
        logic [7:0] val;
        logic [7:0] hue_base;
        logic       hue_neg;
        logic       zero_hue;
        logic       zero_sat;
        logic       sat_clamp;
    } side_t;

    typedef struct packed {
        div_t  sat_div;
        div_t  hue_div;
        side_t side;
    } stage_t;

endpackage

`default_nettype wire

[src/rgb_to_hsv_8bit.sv]
// -----------------------------------------------------------------------------
// rgb_to_hsv_8bit
// Pipelined 8-bit RGB to HSV pixel converter.
// -----------------------------------------------------------------------------
// One pixel enters on any cycle that start is high; busy never rises, so a
// new pixel can follow in every clock cycle. Each pixel's result appears
// on result for one cycle with done high, in input order; there is no
// backpressure, so capture it on that cycle. Each pixel passes in turn
// through the registered pipeline: one input stage computes max,
// min and the hue and saturation operands, eight division cells each add
// one quotient bit to both the saturation and the hue division, and one
// output register applies the black, gray and clamp rules and the hue
// offset. Value is the largest channel. Saturation is (max-min)*256/max,
// clamped to 255. Hue is 0, 85 or 171 for a red, green or blue dominant
// channel (ties go to red, then green) plus 43*difference/(max-min),
// truncated toward zero and wrapped to 8 bits. Black and gray pixels give
// hue 0; black gives saturation 0.
// -----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_8bit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire rhsv_pkg::pixel_t pixel,
    output logic                  done,
    output rhsv_pkg::hsv_t        result
);

    localparam int Steps = rhsv_pkg::DIV_STEPS;

    logic                 chain_valid [0:Steps];
    rhsv_pkg::stage_t     chain_stage [0:Steps];
    rhsv_pkg::stage_t     last;
    logic [7:0]           hue_q;
    logic [7:0]           hue_off;
    logic                 done_reg;
    logic                 done_next;
    rhsv_pkg::hsv_t       result_reg;
    rhsv_pkg::hsv_t       result_next;

    // Never stall: every pixel advances one stage per cycle
    assign busy = 1'b0;

    rhsv_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (start && !busy),
        .pixel    (pixel),
        .dn_valid (chain_valid[0]),
        .dn_stage (chain_stage[0])
    );

    // Division chain: each cell produces one quotient bit per division
    for (genvar i = 0; i < Steps; i++)
    begin : g_cell
        rhsv_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[i]),
            .up_stage (chain_stage[i]),
            .dn_valid (chain_valid[i+1]),
            .dn_stage (chain_stage[i+1])
        );
    end

    // Output stage: apply special cases and the hue offset
    always_comb
    begin
        last    = chain_stage[Steps];
        hue_q   = last.hue_div.quo;
        hue_off = last.side.hue_neg ? (8'd0 - hue_q) : hue_q;

        result_next.val_out = last.side.val;

        // Black forces zero saturation; a full span clamps the 256 case
        priority if (last.side.zero_sat)
        begin
            result_next.sat_out = 8'd0;
        end
        else if (last.side.sat_clamp)
        begin
            result_next.sat_out = rhsv_pkg::SAT_MAX;
        end
        else
        begin
            result_next.sat_out = last.sat_div.quo;
        end

        // Gray and black pixels have no hue; the sum wraps modulo 256
        if (last.side.zero_hue)
        begin
            result_next.hue_out = 8'd0;
        end
        else
        begin
            result_next.hue_out = last.side.hue_base + hue_off;
        end

        done_next = chain_valid[Steps];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    // Hold the result data without reset; done marks it
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[src/rhsv_div_cell.sv]
// -----------------------------------------------------------------------------
// rhsv_div_cell
// One cell of the division chain: one restoring step of each division.
// -----------------------------------------------------------------------------
`default_nettype none

module rhsv_div_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             up_valid,
    input  wire rhsv_pkg::stage_t up_stage,
    output logic                  dn_valid,
    output rhsv_pkg::stage_t      dn_stage
);

    function automatic rhsv_pkg::div_t div_step(input rhsv_pkg::div_t d);
        rhsv_pkg::div_t r;
        logic [8:0]     trial;
        logic [8:0]     sub;
        logic           ge;
        trial  = {d.rem, d.feed[7]};
        sub    = trial - {1'b0, d.den};
        ge     = (trial >= {1'b0, d.den});
        r.rem  = ge ? sub[7:0] : trial[7:0];
        r.den  = d.den;
        r.feed = {d.feed[6:0], 1'b0};
        r.quo  = {d.quo[6:0], ge};
        return r;
    endfunction

    logic             valid_reg;
    logic             valid_next;
    rhsv_pkg::stage_t stage_reg;
    rhsv_pkg::stage_t stage_next;

    always_comb
    begin
        valid_next         = up_valid;
        stage_next.sat_div = div_step(up_stage.sat_div);
        stage_next.hue_div = div_step(up_stage.hue_div);
        stage_next.side    = up_stage.side;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign dn_valid = valid_reg;
    assign dn_stage = stage_reg;

endmodule

`default_nettype wire

[src/rhsv_front.sv]
// -----------------------------------------------------------------------------
// rhsv_front
// Input stage: max, min, dominant channel and division operands.
// -----------------------------------------------------------------------------
`default_nettype none

module rhsv_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             take,
    input  wire rhsv_pkg::pixel_t pixel,
    output logic                  dn_valid,
    output rhsv_pkg::stage_t      dn_stage
);

    logic [7:0]       hi;
    logic [7:0]       lo;
    logic [7:0]       span;
    logic [7:0]       op_a;
    logic [7:0]       op_b;
    logic [8:0]       diff;
    logic [7:0]       mag;
    logic [13:0]      prod;
    logic             valid_reg;
    logic             valid_next;
    rhsv_pkg::stage_t stage_reg;
    rhsv_pkg::stage_t stage_next;

    always_comb
    begin
        hi = (pixel.red_in > pixel.green_in) ? pixel.red_in : pixel.green_in;
        hi = (hi > pixel.blue_in) ? hi : pixel.blue_in;
        lo = (pixel.red_in < pixel.green_in) ? pixel.red_in : pixel.green_in;
        lo = (lo < pixel.blue_in) ? lo : pixel.blue_in;
        span = hi - lo;

        stage_next = '0;
        // Dominant channel, ties go to red, then green
        priority if (hi == pixel.red_in)
        begin
            stage_next.side.hue_base = rhsv_pkg::HUE_BASE_RED;
            op_a = pixel.green_in;
            op_b = pixel.blue_in;
        end
        else if (hi == pixel.green_in)
        begin
            stage_next.side.hue_base = rhsv_pkg::HUE_BASE_GREEN;
            op_a = pixel.blue_in;
            op_b = pixel.red_in;
        end
        else
        begin
            stage_next.side.hue_base = rhsv_pkg::HUE_BASE_BLUE;
            op_a = pixel.red_in;
            op_b = pixel.green_in;
        end

        diff = {1'b0, op_a} - {1'b0, op_b};
        mag  = diff[8] ? 8'(-diff) : diff[7:0];
        prod = 14'(mag) * 14'(rhsv_pkg::HUE_SCALE);

        stage_next.side.val       = hi;
        stage_next.side.hue_neg   = diff[8];
        stage_next.side.zero_hue  = (span == 8'd0);
        stage_next.side.zero_sat  = (hi == 8'd0);
        stage_next.side.sat_clamp = (span == hi);

        // span*256/hi, used when span < hi: remainder starts at span, shift in zeros
        stage_next.sat_div.rem  = span;
        stage_next.sat_div.den  = hi;
        stage_next.sat_div.feed = 8'd0;
        stage_next.sat_div.quo  = 8'd0;

        // 43*|diff|/span: high bits of the product are already below span
        stage_next.hue_div.rem  = {2'b00, prod[13:8]};
        stage_next.hue_div.den  = span;
        stage_next.hue_div.feed = prod[7:0];
        stage_next.hue_div.quo  = 8'd0;

        valid_next = take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign dn_valid = valid_reg;
    assign dn_stage = stage_reg;

endmodule

`default_nettype wire

[src/rhsv_checker.sv]
// -----------------------------------------------------------------------------
// rhsv_checker
// Port-level checks for the RGB to HSV converter, bound to the top level.
// -----------------------------------------------------------------------------
`default_nettype none

`include "rgb_to_hsv_8bit_defines.svh"

module rhsv_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             done,
    input wire rhsv_pkg::hsv_t   result
);

    localparam int Lat = rhsv_pkg::LATENCY;

    logic black_seen;
    logic gray_seen;
    logic accept;
    logic black_clean;

    assign accept      = start && !busy;
    assign black_seen  = done && (result.val_out == 8'd0);
    assign gray_seen   = done && (result.sat_out == 8'd0);
    assign black_clean = (result.hue_out == 8'd0) && (result.sat_out == 8'd0);

    // Every accepted transaction comes out a fixed number of cycles later
    `RHSV_ASSERT_DELAY(a_fixed_latency, accept, Lat, done)
    // The converter never holds off a transaction
    `RHSV_ASSERT_NOW(a_never_busy, 1'b1, !busy)
    // Black pixels carry no hue and no saturation
    `RHSV_ASSERT_NOW(a_black_result, black_seen, black_clean)
    // Zero saturation only arises for gray or black, which have no hue
    `RHSV_ASSERT_NOW(a_gray_result, gray_seen, result.hue_out == 8'd0)

endmodule

bind rgb_to_hsv_8bit rhsv_checker u_rhsv_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire
